// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/gitt_pkg.sv =====
package gitt_pkg;

    localparam int unsigned HITS_BITS = 8;
    localparam int unsigned AGE_BITS  = 9;
    localparam int unsigned ID_BITS   = 16;
    localparam logic [AGE_BITS-1:0]  AGE_MAX = '1;
    localparam logic [HITS_BITS-1:0] HITS_MAX = '1;
    localparam logic [ID_BITS-1:0]   ID_MAX = '1;

    typedef enum logic [1:0] {
        REG_MAX_AGE  = 2'd0,
        REG_MIN_HITS = 2'd1,
        REG_IOU_THR  = 2'd2
    } cfg_index_t;

    // Per-slot record fields other than the box.
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [AGE_BITS-1:0]  age;
        logic [HITS_BITS-1:0] hits;
    } slot_meta_t;

endpackage

// ===== hw/rtl/gitt_iou_cmp.sv =====
module gitt_iou_cmp
    import gitt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [COORD_BITS-1:0]   ax,
    input  logic [COORD_BITS-1:0]   ay,
    input  logic [COORD_BITS-1:0]   aw,
    input  logic [COORD_BITS-1:0]   ah,
    input  logic [COORD_BITS-1:0]   bx,
    input  logic [COORD_BITS-1:0]   by,
    input  logic [COORD_BITS-1:0]   bw,
    input  logic [COORD_BITS-1:0]   bh,
    output logic                    done,
    output logic [2*COORD_BITS+1:0] inter,
    output logic [2*COORD_BITS+1:0] uni
);

    localparam int CB = COORD_BITS;
    localparam int AW = 2 * CB + 2;

    logic [CB:0]   dx_reg, dy_reg;
    logic [2*CB-1:0] area_a_reg, area_b_reg;
    logic          s1_reg;
    logic [AW-1:0] inter_reg, uni_reg;
    logic          s2_reg;

    logic [CB:0] x0, y0, x1, y1, ra, rb, ba, bb;
    logic [AW-1:0] inter_c;

    always_comb begin
        x0 = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
        y0 = (ay > by) ? {1'b0, ay} : {1'b0, by};
        ra = {1'b0, ax} + {1'b0, aw};
        rb = {1'b0, bx} + {1'b0, bw};
        ba = {1'b0, ay} + {1'b0, ah};
        bb = {1'b0, by} + {1'b0, bh};
        x1 = (ra < rb) ? ra : rb;
        y1 = (ba < bb) ? ba : bb;
        inter_c = AW'(dx_reg) * AW'(dy_reg);
    end

    always_ff @(posedge aclk) begin
        if (x1 > x0 && y1 > y0) begin
            dx_reg <= x1 - x0;
            dy_reg <= y1 - y0;
        end else begin
            dx_reg <= '0;
            dy_reg <= '0;
        end
        area_a_reg <= (2*CB)'(aw) * (2*CB)'(ah);
        area_b_reg <= (2*CB)'(bw) * (2*CB)'(bh);
        inter_reg  <= inter_c;
        uni_reg    <= AW'(area_a_reg) + AW'(area_b_reg) - inter_c;
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= start;
            s2_reg <= s1_reg;
        end
    end

    assign done  = s2_reg;
    assign inter = inter_reg;
    assign uni   = uni_reg;

endmodule

// ===== hw/rtl/gitt_mul_cmp.sv =====
module gitt_mul_cmp #(
    parameter int W = 26
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    input  logic [W-1:0] d,
    output logic         done,
    output logic         greater
);

    localparam int HW = (W + 1) / 2;
    localparam int PW = 2 * W;

    // a*b and c*d each built from four half-width partial products, registered and then summed into a register.
    logic [HW-1:0] al, ah, bl, bh, cl, ch, dl, dh;
    logic [PW-1:0] p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [PW-1:0] q_ll_reg, q_lh_reg, q_hl_reg, q_hh_reg;
    logic [PW-1:0] ab_reg, cd_reg;
    logic          s1_reg, s2_reg;

    assign al = HW'(a);
    assign ah = HW'(a >> HW);
    assign bl = HW'(b);
    assign bh = HW'(b >> HW);
    assign cl = HW'(c);
    assign ch = HW'(c >> HW);
    assign dl = HW'(d);
    assign dh = HW'(d >> HW);

    always_ff @(posedge aclk) begin
        p_ll_reg <= PW'(al) * PW'(bl);
        p_lh_reg <= PW'(al) * PW'(bh);
        p_hl_reg <= PW'(ah) * PW'(bl);
        p_hh_reg <= PW'(ah) * PW'(bh);
        q_ll_reg <= PW'(cl) * PW'(dl);
        q_lh_reg <= PW'(cl) * PW'(dh);
        q_hl_reg <= PW'(ch) * PW'(dl);
        q_hh_reg <= PW'(ch) * PW'(dh);
        ab_reg <= p_ll_reg + ((p_lh_reg + p_hl_reg) << HW) + (p_hh_reg << (2*HW));
        cd_reg <= q_ll_reg + ((q_lh_reg + q_hl_reg) << HW) + (q_hh_reg << (2*HW));
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= start;
            s2_reg <= s1_reg;
        end
    end

    assign done    = s2_reg;
    assign greater = ab_reg > cd_reg;

endmodule

// ===== hw/rtl/greedy_iou_track_table.sv =====
// Greedy IoU track table.
// Detections enter on the s_ channel (valid/ready), one box per item; frame_end
// marks the last box of a frame; a no_detections item carries no box and
// ends the frame. Each box is compared against every live, not yet matched
// track in slot order (memory read, IoU pipe, exact cross-product compare),
// skipping free and matched slots, and holds s_ready low until it is done.
// At frame end the table is aged and compacted, pending births are written
// into free slots (a birth with no free slot is dropped), and the report is
// scanned and streamed on the m_ channel, one item per reported track, ending
// with last_track. A report always has at least one item. The report goes out
// through an output register; while the receiver stalls, the scan holds and
// s_ready stays low until the last item of the report is in the output
// register.
// Configuration writes on the cfg channel are taken at any time and must only
// be issued while the block is idle. Reset clears all tracks, sets the next id
// to one and restores register defaults; no clearing pass is needed.
module greedy_iou_track_table
    import gitt_pkg::*;
#(
    parameter int MAX_TRACKS = 32,
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_box_x,
    input  logic [COORD_BITS-1:0] s_box_y,
    input  logic [COORD_BITS-1:0] s_box_w,
    input  logic [COORD_BITS-1:0] s_box_h,
    input  logic                  s_frame_end,
    input  logic                  s_no_detections,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_track_valid,
    output logic [ID_BITS-1:0]    m_track_id,
    output logic [COORD_BITS-1:0] m_out_x,
    output logic [COORD_BITS-1:0] m_out_y,
    output logic [COORD_BITS-1:0] m_out_w,
    output logic [COORD_BITS-1:0] m_out_h,
    output logic [HITS_BITS-1:0]  m_out_hits,
    output logic                  m_last_track,
    output logic                  m_table_overflow,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int SB = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int BW = 4 * CB;
    localparam int AW = 2 * CB + 2;
    localparam int MW = AW;
    localparam logic [CW-1:0] N_SLOTS = CW'(MAX_TRACKS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_WAIT, ST_IOU, ST_THR, ST_CMP, ST_NEXT, ST_HIT,
        ST_AG_RD, ST_AG_WAIT, ST_AG_WR, ST_BR_FIND, ST_BR_RD, ST_BR_WAIT,
        ST_BR_WR, ST_RP_RD, ST_RP_WAIT, ST_RP_OUT, ST_RP_EMPTY, ST_RP_DRAIN
    } state_t;

    // Track memory and pending-birth memory, with registered read ports.
    logic [BW-1:0]          box_mem  [MAX_TRACKS];
    slot_meta_t             meta_mem [MAX_TRACKS];
    logic [BW-1:0]          pend_mem [MAX_TRACKS];
    logic [BW-1:0]          box_rd_reg, pend_rd_reg;
    slot_meta_t             meta_rd_reg;

    logic [MAX_TRACKS-1:0]  used_reg, matched_reg;
    logic [SB-1:0]          raddr, waddr, praddr;
    logic                   box_we, meta_we, pend_we;
    logic [BW-1:0]          box_wd;
    slot_meta_t             meta_wd;

    state_t                 state_reg;
    logic [7:0]             max_age_reg, min_hits_reg;
    logic [15:0]            thr_reg;
    logic [CW-1:0]          t_reg, w_reg, p_reg, pend_cnt_reg;
    logic [ID_BITS-1:0]     next_id_reg;
    logic                   ovf_reg, seen_reg, filter_reg, fend_reg;
    logic [BW-1:0]          det_reg;
    logic                   best_ok_reg;
    logic [SB-1:0]          best_reg;
    logic [AW-1:0]          b_inter_reg, b_uni_reg;
    logic [AW-1:0]          c_inter_reg, c_uni_reg;
    logic                   any_out_reg;

    logic                   iou_start, iou_done, cmp_start, cmp_done, cmp_gt;
    logic [AW-1:0]          iou_inter, iou_uni;
    logic [MW-1:0]          ca, cb, cc, cd;
    logic [SB-1:0]          t_idx;
    logic                   free_found;
    logic [SB-1:0]          free_idx;

    logic                   m_valid_reg;
    logic                   o_tv_reg, o_last_reg, o_ovf_reg;
    logic [ID_BITS-1:0]     o_id_reg;
    logic [BW-1:0]          o_box_reg;
    logic [HITS_BITS-1:0]   o_hits_reg;

    // Hit write-back happens in the cycle after the metadata read of the best slot is issued.
    logic                   hit_wr_reg;
    logic [SB-1:0]          hit_addr_reg;
    logic [HITS_BITS-1:0]   hit_hits;

    // One report entry is held back so the final one can carry last_track.
    logic [ID_BITS-1:0]     h_id_reg;
    logic [BW-1:0]          h_box_reg;
    logic [HITS_BITS-1:0]   h_hits_reg;

    assign t_idx = t_reg[SB-1:0];

    always_ff @(posedge aclk) begin
        if (box_we)  box_mem[waddr]  <= box_wd;
        if (meta_we) meta_mem[waddr] <= meta_wd;
        if (pend_we) pend_mem[pend_cnt_reg[SB-1:0]] <= det_reg;
        box_rd_reg  <= box_mem[raddr];
        meta_rd_reg <= meta_mem[raddr];
        pend_rd_reg <= pend_mem[praddr];
    end

    gitt_iou_cmp #(.COORD_BITS(CB)) u_iou (
        .aclk(aclk), .aresetn(aresetn), .start(iou_start),
        .ax(det_reg[4*CB-1:3*CB]), .ay(det_reg[3*CB-1:2*CB]),
        .aw(det_reg[2*CB-1:CB]), .ah(det_reg[CB-1:0]),
        .bx(box_rd_reg[4*CB-1:3*CB]), .by(box_rd_reg[3*CB-1:2*CB]),
        .bw(box_rd_reg[2*CB-1:CB]), .bh(box_rd_reg[CB-1:0]),
        .done(iou_done), .inter(iou_inter), .uni(iou_uni)
    );

    gitt_mul_cmp #(.W(MW)) u_cmp (
        .aclk(aclk), .aresetn(aresetn), .start(cmp_start),
        .a(ca), .b(cb), .c(cc), .d(cd), .done(cmp_done), .greater(cmp_gt)
    );

    // Without a match held: inter*65536 > thr*uni; otherwise inter*b_uni > b_inter*uni.
    always_comb begin
        ca = iou_inter;
        cd = iou_uni;
        if (best_ok_reg) begin
            cb = b_uni_reg;
            cc = b_inter_reg;
        end else begin
            cb = MW'(65536);
            cc = MW'(thr_reg);
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SB'(i);
            end
        end
    end

    always_comb begin
        hit_hits = (meta_rd_reg.hits == HITS_MAX) ? HITS_MAX : meta_rd_reg.hits + 1'b1;
    end

    always_comb begin
        raddr     = t_idx;
        praddr    = p_reg[SB-1:0];
        waddr     = t_idx;
        box_we    = 1'b0;
        meta_we   = 1'b0;
        pend_we   = 1'b0;
        box_wd    = det_reg;
        meta_wd   = meta_rd_reg;
        iou_start = (state_reg == ST_WAIT);
        cmp_start = 1'b0;
        case (state_reg)
            ST_HIT: begin
                raddr   = best_reg;
                pend_we = !best_ok_reg && (pend_cnt_reg < N_SLOTS);
            end
            ST_AG_WR: begin
                waddr   = w_reg[SB-1:0];
                box_wd  = box_rd_reg;
                box_we  = 1'b1;
                meta_we = 1'b1;
                meta_wd = meta_rd_reg;
                if (!matched_reg[t_idx] && meta_rd_reg.age != AGE_MAX) begin
                    meta_wd.age = meta_rd_reg.age + 1'b1;
                end
            end
            ST_BR_WR: begin
                waddr   = free_idx;
                box_wd  = pend_rd_reg;
                box_we  = 1'b1;
                meta_we = 1'b1;
                meta_wd.id   = next_id_reg;
                meta_wd.age  = '0;
                meta_wd.hits = HITS_BITS'(1);
            end
            default: ;
        endcase
        if (hit_wr_reg) begin
            waddr        = hit_addr_reg;
            box_we       = 1'b1;
            box_wd       = det_reg;
            meta_we      = 1'b1;
            meta_wd      = meta_rd_reg;
            meta_wd.age  = '0;
            meta_wd.hits = hit_hits;
        end
        if (state_reg == ST_IOU && iou_done) begin
            cmp_start = (iou_uni != '0);
        end
    end

    logic s_fire, m_fire, out_free;
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid_reg && m_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    logic keep;
    always_comb begin
        keep = !filter_reg || (meta_rd_reg.age == '0 && meta_rd_reg.hits >= min_hits_reg);
    end

    logic [AGE_BITS-1:0] aged;
    always_comb begin
        aged = meta_rd_reg.age;
        if (!matched_reg[t_idx] && meta_rd_reg.age != AGE_MAX) begin
            aged = meta_rd_reg.age + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        hit_wr_reg <= 1'b0;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_age_reg  <= 8'd1;
            min_hits_reg <= 8'd3;
            thr_reg      <= 16'd19661;
            used_reg     <= '0;
            matched_reg  <= '0;
            pend_cnt_reg <= '0;
            next_id_reg  <= ID_BITS'(1);
            ovf_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            t_reg        <= '0;
            w_reg        <= '0;
            p_reg        <= '0;
            best_ok_reg  <= 1'b0;
            filter_reg   <= 1'b0;
            fend_reg     <= 1'b0;
            any_out_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MAX_AGE:  max_age_reg  <= cfg_data[7:0];
                    REG_MIN_HITS: min_hits_reg <= cfg_data[7:0];
                    REG_IOU_THR:  thr_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (m_fire) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        det_reg     <= {s_box_x, s_box_y, s_box_w, s_box_h};
                        fend_reg    <= s_frame_end;
                        t_reg       <= '0;
                        best_ok_reg <= 1'b0;
                        b_inter_reg <= '0;
                        b_uni_reg   <= AW'(1);
                        if (s_no_detections) begin
                            filter_reg <= seen_reg;
                            if (!seen_reg) begin
                                matched_reg  <= '0;
                                pend_cnt_reg <= '0;
                            end
                            w_reg     <= '0;
                            state_reg <= ST_AG_RD;
                        end else begin
                            seen_reg  <= 1'b1;
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT: begin
                    if (t_reg == N_SLOTS) begin
                        state_reg <= ST_HIT;
                    end else if (used_reg[t_idx] && !matched_reg[t_idx]) begin
                        state_reg <= ST_RD;
                    end else begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                ST_RD:   state_reg <= ST_WAIT;
                ST_WAIT: state_reg <= ST_IOU;
                ST_IOU: begin
                    if (iou_done) begin
                        c_inter_reg <= iou_inter;
                        c_uni_reg   <= iou_uni;
                        if (iou_uni == '0) begin
                            t_reg     <= t_reg + 1'b1;
                            state_reg <= ST_NEXT;
                        end else begin
                            state_reg <= best_ok_reg ? ST_CMP : ST_THR;
                        end
                    end
                end
                ST_THR, ST_CMP: begin
                    if (cmp_done) begin
                        if (cmp_gt) begin
                            best_ok_reg <= 1'b1;
                            best_reg    <= t_idx;
                            b_inter_reg <= c_inter_reg;
                            b_uni_reg   <= c_uni_reg;
                        end
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_HIT: begin
                    if (best_ok_reg) begin
                        hit_wr_reg   <= 1'b1;
                        hit_addr_reg <= best_reg;
                        matched_reg[best_reg] <= 1'b1;
                    end else if (pend_cnt_reg < N_SLOTS) begin
                        pend_cnt_reg <= pend_cnt_reg + 1'b1;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                    if (fend_reg) begin
                        filter_reg <= 1'b1;
                        t_reg      <= '0;
                        w_reg      <= '0;
                        state_reg  <= ST_AG_RD;
                    end else begin
                        state_reg <= ST_RP_DRAIN;
                    end
                end
                ST_RP_DRAIN: begin
                    // Lets the hit write-back land before the next item.
                    state_reg <= ST_IDLE;
                end
                ST_AG_RD: begin
                    if (t_reg == N_SLOTS) begin
                        p_reg     <= '0;
                        state_reg <= ST_BR_FIND;
                    end else if (!used_reg[t_idx]) begin
                        t_reg <= t_reg + 1'b1;
                    end else begin
                        state_reg <= ST_AG_WAIT;
                    end
                end
                ST_AG_WAIT: state_reg <= ST_AG_WR;
                ST_AG_WR: begin
                    used_reg[t_idx]    <= 1'b0;
                    matched_reg[t_idx] <= 1'b0;
                    if (aged <= AGE_BITS'(max_age_reg)) begin
                        used_reg[w_reg[SB-1:0]] <= 1'b1;
                        w_reg <= w_reg + 1'b1;
                    end
                    t_reg     <= t_reg + 1'b1;
                    state_reg <= ST_AG_RD;
                end
                ST_BR_FIND: begin
                    if (!filter_reg || p_reg == pend_cnt_reg) begin
                        pend_cnt_reg <= '0;
                        t_reg        <= '0;
                        any_out_reg  <= 1'b0;
                        state_reg    <= ST_RP_RD;
                    end else if (!free_found) begin
                        ovf_reg   <= 1'b1;
                        p_reg     <= p_reg + 1'b1;
                    end else begin
                        state_reg <= ST_BR_RD;
                    end
                end
                ST_BR_RD:   state_reg <= ST_BR_WAIT;
                ST_BR_WAIT: state_reg <= ST_BR_WR;
                ST_BR_WR: begin
                    used_reg[free_idx] <= 1'b1;
                    next_id_reg <= (next_id_reg == ID_MAX) ? ID_BITS'(1)
                                                           : next_id_reg + 1'b1;
                    p_reg     <= p_reg + 1'b1;
                    state_reg <= ST_BR_FIND;
                end
                ST_RP_RD: begin
                    if (t_reg == N_SLOTS) begin
                        state_reg <= ST_RP_EMPTY;
                    end else if (!used_reg[t_idx]) begin
                        t_reg <= t_reg + 1'b1;
                    end else begin
                        state_reg <= ST_RP_WAIT;
                    end
                end
                ST_RP_WAIT: state_reg <= ST_RP_OUT;
                ST_RP_OUT: begin
                    if (!keep) begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= ST_RP_RD;
                    end else if (out_free) begin
                        h_id_reg   <= meta_rd_reg.id;
                        h_box_reg  <= box_rd_reg;
                        h_hits_reg <= meta_rd_reg.hits;
                        if (any_out_reg) begin
                            m_valid_reg <= 1'b1;
                            o_tv_reg    <= 1'b1;
                            o_last_reg  <= 1'b0;
                            o_ovf_reg   <= ovf_reg;
                            o_id_reg    <= h_id_reg;
                            o_box_reg   <= h_box_reg;
                            o_hits_reg  <= h_hits_reg;
                        end
                        any_out_reg <= 1'b1;
                        t_reg       <= t_reg + 1'b1;
                        state_reg   <= ST_RP_RD;
                    end
                end
                ST_RP_EMPTY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        o_last_reg  <= 1'b1;
                        o_ovf_reg   <= ovf_reg;
                        if (any_out_reg) begin
                            o_tv_reg   <= 1'b1;
                            o_id_reg   <= h_id_reg;
                            o_box_reg  <= h_box_reg;
                            o_hits_reg <= h_hits_reg;
                        end else begin
                            o_tv_reg   <= 1'b0;
                            o_id_reg   <= '0;
                            o_box_reg  <= '0;
                            o_hits_reg <= '0;
                        end
                        ovf_reg   <= 1'b0;
                        seen_reg  <= 1'b0;
                        state_reg <= ST_RP_DRAIN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_track_valid    = o_tv_reg;
    assign m_track_id       = o_id_reg;
    assign m_out_x          = o_box_reg[4*CB-1:3*CB];
    assign m_out_y          = o_box_reg[3*CB-1:2*CB];
    assign m_out_w          = o_box_reg[2*CB-1:CB];
    assign m_out_h          = o_box_reg[CB-1:0];
    assign m_out_hits       = o_hits_reg;
    assign m_last_track     = o_last_reg;
    assign m_table_overflow = o_ovf_reg;

endmodule

// ===== hw/rtl/gitt_checker.sv =====
`include "assert_macros.svh"

module gitt_checker
    import gitt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_track_valid,
    input logic [ID_BITS-1:0] m_track_id,
    input logic               m_last_track
);

    `CHK_IMPL(a_id_nonzero, aclk, aresetn, m_valid && m_track_valid, m_track_id != '0, "valid track with id zero")
    `CHK_IMPL(a_empty_is_last, aclk, aresetn, m_valid && !m_track_valid, m_last_track, "empty report item is not last")
    `CHK_IMPL(a_no_take_while_report, aclk, aresetn, m_valid && !m_last_track, !s_ready, "input taken during a report")
    `CHK_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_track_id), "stalled item changed")

endmodule

bind greedy_iou_track_table gitt_checker u_gitt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_track_valid(m_track_valid),
    .m_track_id(m_track_id), .m_last_track(m_last_track)
);

// ===== bench/greedy_iou_track_table_tb.sv =====
module greedy_iou_track_table_tb;
    import gitt_pkg::*;

    localparam int NSLOT = 32;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } box_t;

    typedef struct packed {
        box_t box;
        logic fe;
        logic nd;
    } det_item_t;

    typedef struct packed {
        logic        tv;
        logic [15:0] id;
        box_t        box;
        logic [7:0]  hits;
        logic        last;
        logic        ovf;
    } track_rpt_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [11:0] s_box_x = '0, s_box_y = '0, s_box_w = '0, s_box_h = '0;
    logic s_frame_end = 1'b0;
    logic s_no_detections = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_track_valid;
    logic [ID_BITS-1:0] m_track_id;
    logic [11:0] m_out_x, m_out_y, m_out_w, m_out_h;
    logic [HITS_BITS-1:0] m_out_hits;
    logic m_last_track, m_table_overflow;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    greedy_iou_track_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_box_x(s_box_x), .s_box_y(s_box_y), .s_box_w(s_box_w), .s_box_h(s_box_h),
        .s_frame_end(s_frame_end), .s_no_detections(s_no_detections),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_track_valid(m_track_valid), .m_track_id(m_track_id),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_w(m_out_w), .m_out_h(m_out_h),
        .m_out_hits(m_out_hits), .m_last_track(m_last_track),
        .m_table_overflow(m_table_overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Track table model.
    logic [7:0]  age_limit = 8'd1;
    logic [7:0]  hits_needed = 8'd3;
    logic [15:0] iou_thr = 16'd19661;
    logic        trk_used[NSLOT];
    logic [15:0] trk_id[NSLOT];
    box_t        trk_box[NSLOT];
    logic [8:0]  trk_age[NSLOT];
    logic [7:0]  trk_hits[NSLOT];
    logic        trk_matched[NSLOT];
    box_t        newborn_box[NSLOT];
    int          newborn_cnt = 0;
    logic [15:0] next_id = 16'd1;
    logic        overflow_flag = 1'b0;
    logic        frame_has_det = 1'b0;

    track_rpt_t  report_q[$];
    det_item_t   det_q[$];
    int          fail_cnt = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    initial begin
        for (int t = 0; t < NSLOT; t++) begin
            trk_used[t] = 1'b0;
            trk_matched[t] = 1'b0;
        end
    end

    function automatic void box_overlap(input box_t a, input box_t b,
                                        output longint unsigned inter,
                                        output longint unsigned uni);
        longint unsigned x0, y0, x1, y1;
        x0 = (a.x > b.x) ? a.x : b.x;
        y0 = (a.y > b.y) ? a.y : b.y;
        x1 = ((a.x + 64'(a.w)) < (b.x + 64'(b.w))) ? a.x + 64'(a.w) : b.x + 64'(b.w);
        y1 = ((a.y + 64'(a.h)) < (b.y + 64'(b.h))) ? a.y + 64'(a.h) : b.y + 64'(b.h);
        inter = 0;
        if (x1 > x0 && y1 > y0)
            inter = (x1 - x0) * (y1 - y0);
        uni = 64'(a.w) * 64'(a.h) + 64'(b.w) * 64'(b.h) - inter;
    endfunction

    function automatic void age_tracks();
        int w;
        w = 0;
        for (int t = 0; t < NSLOT; t++) begin
            if (trk_used[t]) begin
                if (!trk_matched[t] && trk_age[t] < 9'd511)
                    trk_age[t] = trk_age[t] + 9'd1;
                trk_matched[t] = 1'b0;
                if (trk_age[t] > {1'b0, age_limit}) begin
                    trk_used[t] = 1'b0;
                end else begin
                    if (w != t) begin
                        trk_used[w] = 1'b1;
                        trk_id[w] = trk_id[t];
                        trk_box[w] = trk_box[t];
                        trk_age[w] = trk_age[t];
                        trk_hits[w] = trk_hits[t];
                        trk_matched[w] = 1'b0;
                        trk_used[t] = 1'b0;
                    end
                    w++;
                end
            end
        end
    endfunction

    function automatic void birth_tracks();
        int t;
        for (int p = 0; p < newborn_cnt; p++) begin
            t = 0;
            while (t < NSLOT && trk_used[t])
                t++;
            if (t >= NSLOT) begin
                overflow_flag = 1'b1;
            end else begin
                trk_used[t] = 1'b1;
                trk_id[t] = next_id;
                next_id = (next_id == 16'hffff) ? 16'd1 : next_id + 16'd1;
                trk_box[t] = newborn_box[p];
                trk_age[t] = '0;
                trk_hits[t] = 8'd1;
                trk_matched[t] = 1'b0;
            end
        end
        newborn_cnt = 0;
    endfunction

    function automatic void emit_report(input logic filter);
        track_rpt_t r;
        int n;
        n = 0;
        for (int t = 0; t < NSLOT; t++) begin
            if (trk_used[t] && !(filter && !(trk_age[t] == 0 && trk_hits[t] >= hits_needed)))
            begin
                r.tv = 1'b1;
                r.id = trk_id[t];
                r.box = trk_box[t];
                r.hits = trk_hits[t];
                r.last = 1'b0;
                r.ovf = overflow_flag;
                report_q = {report_q, r};
                n++;
            end
        end
        if (n == 0) begin
            r = '0;
            r.ovf = overflow_flag;
            report_q = {report_q, r};
        end
        report_q[report_q.size()-1].last = 1'b1;
        overflow_flag = 1'b0;
        frame_has_det = 1'b0;
    endfunction

    function automatic void track_detection(input det_item_t it);
        int best;
        longint unsigned b_inter, b_uni, inter, uni;
        logic better;
        if (!it.nd) begin
            best = -1;
            b_inter = 0;
            b_uni = 1;
            for (int t = 0; t < NSLOT; t++) begin
                if (trk_used[t] && !trk_matched[t]) begin
                    box_overlap(it.box, trk_box[t], inter, uni);
                    if (uni != 0) begin
                        if (best < 0)
                            better = (inter * 65536) > (64'(iou_thr) * uni);
                        else
                            better = (inter * b_uni) > (b_inter * uni);
                        if (better) begin
                            best = t;
                            b_inter = inter;
                            b_uni = uni;
                        end
                    end
                end
            end
            if (best >= 0) begin
                trk_box[best] = it.box;
                trk_age[best] = '0;
                if (trk_hits[best] < 8'd255)
                    trk_hits[best] = trk_hits[best] + 8'd1;
                trk_matched[best] = 1'b1;
            end else if (newborn_cnt < NSLOT) begin
                newborn_box[newborn_cnt] = it.box;
                newborn_cnt++;
            end else begin
                overflow_flag = 1'b1;
            end
            frame_has_det = 1'b1;
            if (!it.fe)
                return;
        end
        if (!frame_has_det) begin
            for (int t = 0; t < NSLOT; t++)
                trk_matched[t] = 1'b0;
            age_tracks();
            newborn_cnt = 0;
            emit_report(1'b0);
        end else begin
            age_tracks();
            birth_tracks();
            emit_report(1'b1);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                track_detection('{box: '{s_box_x, s_box_y, s_box_w, s_box_h},
                                  fe: s_frame_end, nd: s_no_detections});
            if (det_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                det_item_t it;
                it = det_q.pop_front();
                s_valid <= 1'b1;
                s_box_x <= it.box.x;
                s_box_y <= it.box.y;
                s_box_w <= it.box.w;
                s_box_h <= it.box.h;
                s_frame_end <= it.fe;
                s_no_detections <= it.nd;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                track_rpt_t got, want;
                got = '{m_track_valid, m_track_id, '{m_out_x, m_out_y, m_out_w, m_out_h},
                        m_out_hits, m_last_track, m_table_overflow};
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected item: actual %p", $time, got);
                    fail_cnt++;
                end else begin
                    want = report_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected %p actual %p", $time, want, got);
                        fail_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAX_AGE:  age_limit = val[7:0];
            REG_MIN_HITS: hits_needed = val[7:0];
            REG_IOU_THR:  iou_thr = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (det_q.size() > 0 || s_valid || report_q.size() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void push_det(input box_t b, input logic fe, input logic nd);
        det_item_t it;
        it = '{box: b, fe: fe, nd: nd};
        det_q = {det_q, it};
    endfunction

    function automatic box_t rand_box(input int wmax);
        box_t b;
        b.x = $urandom_range(0, 4095);
        b.y = $urandom_range(0, 4095);
        b.w = $urandom_range(1, wmax);
        b.h = $urandom_range(1, wmax);
        return b;
    endfunction

    box_t recent[$];

    function automatic box_t pick_box();
        box_t b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && recent.size() > 0) begin
            b = recent[$urandom_range(0, recent.size() - 1)];
            b.x = b.x + 12'($urandom_range(0, 8)) - 12'd4;
            b.y = b.y + 12'($urandom_range(0, 8)) - 12'd4;
            b.w = b.w + 12'($urandom_range(0, 4));
            b.h = b.h + 12'($urandom_range(0, 4));
        end else if (r < 90) begin
            b = rand_box(400);
        end else begin
            b = 48'({$urandom, $urandom});
        end
        recent = {recent, b};
        if (recent.size() > 40)
            void'(recent.pop_front());
        return b;
    endfunction

    task automatic random_frames(input int n_items, input int burst);
        int sent, n, kind;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                push_det(48'({$urandom, $urandom}), $urandom_range(0, 1), 1'b1);
                sent++;
            end else begin
                n = (kind < 14) ? burst : $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    push_det(pick_box(), k == n - 1, 1'b0);
                sent += n;
                if (kind < 20) begin
                    // Frame closed by an empty item after detections.
                    det_q[det_q.size()-1].fe = 1'b0;
                    push_det(48'({$urandom, $urandom}), $urandom_range(0, 1), 1'b1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        push_det('0, 1'b0, 1'b1);
        push_det('{12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b1, 1'b0);
        push_det('{12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b1, 1'b0);
        push_det('{12'd1, 12'd1, 12'd4094, 12'd4094}, 1'b1, 1'b0);
        push_det('{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b0, 1'b0);
        push_det('{12'd100, 12'd100, 12'd0, 12'd0}, 1'b1, 1'b0);
        push_det('{12'd100, 12'd100, 12'd0, 12'd0}, 1'b1, 1'b0);
        push_det('{12'd10, 12'd20, 12'd30, 12'd40}, 1'b0, 1'b0);
        push_det('{12'hfff, 12'hfff, 12'hfff, 12'hfff}, 1'b1, 1'b1);
        push_det('0, 1'b0, 1'b1);
        push_det('{12'd12, 12'd22, 12'd30, 12'd40}, 1'b1, 1'b0);
        push_det('0, 1'b1, 1'b1);
        push_det('0, 1'b0, 1'b1);
        drain();

        write_reg(REG_MAX_AGE, 16'd0);
        write_reg(REG_MIN_HITS, 16'd0);
        write_reg(REG_IOU_THR, 16'd0);
        idle_pct = 45;
        stall_pct = 0;
        random_frames(110, 8);
        drain();

        write_reg(REG_MAX_AGE, 16'd255);
        write_reg(REG_MIN_HITS, 16'd1);
        write_reg(REG_IOU_THR, 16'd65535);
        idle_pct = 0;
        stall_pct = 45;
        random_frames(110, 12);
        drain();

        // Long-lived tracks and big frames fill the table.
        write_reg(REG_MAX_AGE, 16'hff40);
        write_reg(REG_MIN_HITS, 16'd255);
        write_reg(REG_IOU_THR, 16'd32768);
        idle_pct = 24;
        stall_pct = 24;
        recent.delete();
        random_frames(120, 36);
        drain();

        write_reg(REG_MAX_AGE, 16'd2);
        write_reg(REG_MIN_HITS, 16'd2);
        write_reg(REG_IOU_THR, 16'd19661);
        idle_pct = 0;
        stall_pct = 0;
        random_frames(110, 6);
        drain();

        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #30000000;
        $display("status: fail");
        $finish;
    end

endmodule
